### sv/bbpcl_pkg.sv
// bbpcl_pkg: shared constants, codes and register indexes for the buck/boost pwm
// current limiter. No dependencies; imported by the interfaces and the top level.
`default_nettype none

package bbpcl_pkg;

   // default configuration of the converter
   localparam int PWM_TOP_DEFAULT    = 188;
   localparam int TRIP_DELAY_DEFAULT = 100;
   localparam int ADC_BITS_DEFAULT   = 10;

   // fixed field widths
   localparam int MODE_W  = 2;
   localparam int TGT_W   = 10;
   localparam int DUTY_W  = 8;
   localparam int CORR_W  = 7;
   localparam int STATE_W = 2;
   localparam int TMO_W   = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   localparam logic [CORR_W-1:0] CORR_MAX = 7'd127;

   // request kinds
   localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_TICK   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REARM  = 2'd2;

   // limiter status codes
   localparam logic [STATE_W-1:0] LIMIT_NORMAL  = 2'd0;
   localparam logic [STATE_W-1:0] LIMIT_ACTIVE  = 2'd1;
   localparam logic [STATE_W-1:0] LIMIT_TRIPPED = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_VOLTAGE_TARGET = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CURRENT_LIMIT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_BASE      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BOOST_MODE     = 2'd3;

   localparam logic [TGT_W-1:0] CURRENT_LIMIT_RESET = 10'd3;

endpackage

`default_nettype wire

### sv/bbpcl_if.sv
// bbpcl request and response channel interfaces (valid/ready with payload)
// depends on bbpcl_pkg for field widths
`default_nettype none

interface bbpcl_req_if #(
   parameter int ADC_BITS = bbpcl_pkg::ADC_BITS_DEFAULT
);
   import bbpcl_pkg::*;
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [ADC_BITS-1:0] voltage_sample;
   logic [ADC_BITS-1:0] current_sample;

   modport source (output valid, output mode, output voltage_sample,
                   output current_sample, input ready);
   modport sink   (input valid, input mode, input voltage_sample,
                   input current_sample, output ready);
endinterface

interface bbpcl_rsp_if;
   import bbpcl_pkg::*;
   logic               valid;
   logic               ready;
   logic [DUTY_W-1:0]  duty;
   logic [STATE_W-1:0] limit_state;
   logic               power_cut;

   modport source (output valid, output duty, output limit_state,
                   output power_cut, input ready);
   modport sink   (input valid, input duty, input limit_state,
                   input power_cut, output ready);
endinterface

`default_nettype wire

### sv/buck_boost_pwm_current_limiter.sv
// buck/boost pwm duty controller with current limiting and overcurrent trip
// depends on bbpcl_pkg and the bbpcl_req_if / bbpcl_rsp_if channel interfaces
`default_nettype none

// Takes one request per clock while the response is not stalled and returns
// exactly one response per request, through the input register and then the
// response register. A sample request filters the voltage, updates the
// current correction and yields a pwm compare value; a tick request averages
// the stored current and ramps the duty ceiling, tripping after the ceiling
// sits at zero for more than TRIP_DELAY ticks; a rearm request clears the
// trip. Sustained rate is one request per cycle, set by the single state
// update path between the two registers; a stalled response backs up through
// ready. Configuration registers must be written through the csr port only
// while no request is in flight; the block itself does not enforce this.
module buck_boost_pwm_current_limiter #(
   parameter int PWM_TOP    = bbpcl_pkg::PWM_TOP_DEFAULT,
   parameter int TRIP_DELAY = bbpcl_pkg::TRIP_DELAY_DEFAULT,
   parameter int ADC_BITS   = bbpcl_pkg::ADC_BITS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   bbpcl_req_if.sink                            req_ch,
   bbpcl_rsp_if.source                          rsp_ch,
   input  wire logic                            csr_we,
   input  wire logic [bbpcl_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [bbpcl_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bbpcl_pkg::*;

   // width of the correction filter sum and of magnitude compares
   localparam int CW = ((ADC_BITS > 9) ? ADC_BITS : 9) + 1;
   localparam int VW = (ADC_BITS > TGT_W) ? ADC_BITS : TGT_W;
   localparam logic [DUTY_W-1:0] TOP_CODE   = DUTY_W'(PWM_TOP);
   localparam logic [TMO_W-1:0]  DELAY_CODE = TMO_W'(TRIP_DELAY);

   // configuration registers
   logic [TGT_W-1:0]  voltage_target_ff;
   logic [TGT_W-1:0]  current_limit_ff;
   logic [DUTY_W-1:0] duty_base_ff;
   logic              boost_mode_ff;

   // input register
   logic                in_valid_ff;
   logic [MODE_W-1:0]   mode_ff;
   logic [ADC_BITS-1:0] vin_ff;
   logic [ADC_BITS-1:0] iin_ff;

   // converter state
   logic [ADC_BITS-1:0] fv_ff,   fv_in;
   logic [ADC_BITS-1:0] last_ff, last_in;
   logic [CORR_W-1:0]   corr_ff, corr_in;
   logic [ADC_BITS-1:0] avg_ff,  avg_in;
   logic [DUTY_W-1:0]   ceil_ff, ceil_in;
   logic [TMO_W-1:0]    tmo_ff,  tmo_in;
   logic [STATE_W-1:0]  trip_ff, trip_in;

   // response register
   logic               out_valid_ff;
   logic [DUTY_W-1:0]  duty_ff, duty_in;

   logic advance;

   // datapath intermediates
   logic [ADC_BITS:0]   v_sum;
   logic [ADC_BITS:0]   half_i;
   logic [ADC_BITS:0]   v_diff;
   logic [ADC_BITS-1:0] fv_new;
   logic [CW-1:0]       corr_sum;
   logic [CW-1:0]       corr_raw;
   logic [CORR_W-1:0]   corr_new;
   logic [DUTY_W:0]     duty_sum;
   logic [DUTY_W-1:0]   duty_top;
   logic [ADC_BITS:0]   avg_sum;
   logic [ADC_BITS-1:0] avg_new;

   // the input stage moves on when the response register is free or drained
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         voltage_target_ff <= '0;
         current_limit_ff  <= CURRENT_LIMIT_RESET;
         duty_base_ff      <= '0;
         boost_mode_ff     <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_VOLTAGE_TARGET: voltage_target_ff <= csr_wdata[TGT_W-1:0];
            CSR_CURRENT_LIMIT:  current_limit_ff  <= csr_wdata[TGT_W-1:0];
            CSR_DUTY_BASE:      duty_base_ff      <= csr_wdata[DUTY_W-1:0];
            CSR_BOOST_MODE:     boost_mode_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // sample path: voltage filter, correction filter, duty clamp; tick path: current average
   always_comb begin
      v_sum  = {1'b0, fv_ff} + {1'b0, vin_ff};
      half_i = {2'b00, last_ff[ADC_BITS-1:1]};
      v_diff = v_sum - half_i;
      // negative intermediate floors at zero
      fv_new = (v_sum >= half_i) ? v_diff[ADC_BITS:1] : '0;

      if (boost_mode_ff) begin
         corr_sum = (CW'(corr_ff) << 2) + CW'(last_ff);
         corr_raw = corr_sum >> 3;
      end else begin
         corr_sum = (CW'(corr_ff) << 1) + CW'(last_ff);
         corr_raw = corr_sum >> 2;
      end
      corr_new = (corr_raw > CW'(CORR_MAX)) ? CORR_MAX : corr_raw[CORR_W-1:0];

      duty_sum = {1'b0, duty_base_ff} + (DUTY_W+1)'(corr_new);
      duty_top = (duty_sum > (DUTY_W+1)'(TOP_CODE)) ? TOP_CODE : duty_sum[DUTY_W-1:0];

      avg_sum = {1'b0, avg_ff} + {1'b0, last_ff};
      avg_new = avg_sum[ADC_BITS:1];
   end

   // state update per request kind
   always_comb begin
      fv_in   = fv_ff;
      last_in = last_ff;
      corr_in = corr_ff;
      avg_in  = avg_ff;
      ceil_in = ceil_ff;
      tmo_in  = tmo_ff;
      trip_in = trip_ff;
      duty_in = '0;
      case (mode_ff)
         MODE_SAMPLE: begin
            fv_in   = fv_new;
            corr_in = corr_new;
            last_in = iin_ff;
            if ((VW'(fv_new) > VW'(voltage_target_ff)) || (trip_ff == LIMIT_TRIPPED)) begin
               duty_in = '0;
            end else if (duty_top > ceil_ff) begin
               // ceiling wins: enter current limiting
               duty_in = ceil_ff;
               trip_in = LIMIT_ACTIVE;
            end else begin
               duty_in = duty_top;
            end
         end
         MODE_TICK: begin
            avg_in = avg_new;
            if ((VW'(avg_new) <= VW'(current_limit_ff)) && (trip_ff != LIMIT_TRIPPED)) begin
               // ramp the ceiling back up; limiting ends at the top
               if (ceil_ff < TOP_CODE) begin
                  ceil_in = ceil_ff + 1'b1;
               end else begin
                  trip_in = LIMIT_NORMAL;
               end
            end else if (ceil_ff != '0) begin
               ceil_in = ceil_ff - 1'b1;
            end else if (tmo_ff > DELAY_CODE) begin
               // held at zero too long: trip and cut power
               tmo_in  = '0;
               trip_in = LIMIT_TRIPPED;
            end else begin
               tmo_in = tmo_ff + 1'b1;
            end
         end
         MODE_REARM: begin
            trip_in = LIMIT_NORMAL;
         end
         default: ;   // unused code changes nothing
      endcase
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         mode_ff <= req_ch.mode;
         vin_ff  <= req_ch.voltage_sample;
         iin_ff  <= req_ch.current_sample;
      end
   end

   // state commits when the request moves into the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff   <= '0;
         last_ff <= '0;
         corr_ff <= '0;
         avg_ff  <= '0;
         ceil_ff <= '0;
         tmo_ff  <= '0;
         trip_ff <= LIMIT_NORMAL;
      end else if (advance) begin
         fv_ff   <= fv_in;
         last_ff <= last_in;
         corr_ff <= corr_in;
         avg_ff  <= avg_in;
         ceil_ff <= ceil_in;
         tmo_ff  <= tmo_in;
         trip_ff <= trip_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         duty_ff <= duty_in;
      end
   end

   logic [STATE_W-1:0] status_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         status_ff <= trip_in;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.duty        = duty_ff;
   assign rsp_ch.limit_state = status_ff;
   assign rsp_ch.power_cut   = (status_ff == LIMIT_TRIPPED);

   // a tripped converter always has its ceiling parked at zero
   a_trip_ceiling: assert property (@(posedge clock) disable iff (reset)
      (trip_ff == LIMIT_TRIPPED) |-> (ceil_ff == '0))
      else $error("tripped with nonzero duty ceiling");

   // the timeout never runs past one beyond the trip delay
   a_tmo_bound: assert property (@(posedge clock) disable iff (reset)
      tmo_ff <= DELAY_CODE + 1'b1)
      else $error("timeout counter out of range");

   // a delivered duty never exceeds the pwm period or the ceiling
   a_duty_bound: assert property (@(posedge clock) disable iff (reset)
      advance |=> (duty_ff <= TOP_CODE) && (duty_ff <= $past(ceil_ff) || duty_ff == '0))
      else $error("duty above period or ceiling");

   // the input stage never drops a request while the response is stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_ch.ready) |=> in_valid_ff)
      else $error("pending request lost under stall");

endmodule

`default_nettype wire

### verif/buck_boost_pwm_current_limiter_tb.sv
`timescale 1ns / 1ps
// testbench for buck_boost_pwm_current_limiter: a directed table, then random request bursts,
// with each response checked against the row's spelled-out values or an in-bench duty/limiter predictor
// depends on bbpcl_pkg, the bbpcl_req_if / bbpcl_rsp_if interfaces and the block itself

module buck_boost_pwm_current_limiter_tb;
   import bbpcl_pkg::*;

   localparam int PWM_TOP       = PWM_TOP_DEFAULT;
   localparam int TRIP_DELAY    = TRIP_DELAY_DEFAULT;
   localparam int ADC_W         = ADC_BITS_DEFAULT;
   localparam int ADC_MAX       = (1 << ADC_W) - 1;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_QUOTA   = 320;

   // the fourth mode code has no meaning, the block just reports status
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [DUTY_W-1:0]  duty;
      logic [STATE_W-1:0] state;
      logic               cut;
   } conv_status_type;

   // one line of the directed script: either a register write or a request,
   // with the response spelled out where it is obvious
   typedef struct packed {
      logic                  is_csr;
      logic [CSR_IDX_W-1:0]  reg_idx;
      logic [CSR_DATA_W-1:0] reg_val;
      logic [MODE_W-1:0]     mode;
      logic [ADC_W-1:0]      volt;
      logic [ADC_W-1:0]      curr;
      logic                  typed_in;
      logic [DUTY_W-1:0]     duty;
      logic [STATE_W-1:0]    state;
      logic                  cut;
   } script_row_type;

   localparam int SCRIPT_LEN = 23;
   localparam script_row_type SCRIPT [0:SCRIPT_LEN-1] = '{
      // reset settings: target 0, limit 3, base 0, step-down filter
      '{1'b0, CSR_VOLTAGE_TARGET, 10'd0, MODE_SAMPLE, 10'd0, 10'd0,
        1'b1, 8'd0, LIMIT_NORMAL, 1'b0},
      // filtered voltage jumps above target, duty forced off
      '{1'b0, CSR_VOLTAGE_TARGET, 10'd0, MODE_SAMPLE, 10'd1023, 10'd1023,
        1'b1, 8'd0, LIMIT_NORMAL, 1'b0},
      '{1'b0, CSR_VOLTAGE_TARGET, 10'd0, MODE_UNUSED, 10'd1023, 10'd1023,
        1'b1, 8'd0, LIMIT_NORMAL, 1'b0},
      '{1'b0, CSR_VOLTAGE_TARGET, 10'd0, MODE_REARM, 10'd0, 10'd0,
        1'b1, 8'd0, LIMIT_NORMAL, 1'b0},
      // averaged current above limit with ceiling at zero: timeout starts counting
      '{1'b0, CSR_VOLTAGE_TARGET, 10'd0, MODE_TICK, 10'd1023, 10'd0,
        1'b1, 8'd0, LIMIT_NORMAL, 1'b0},
      '{1'b1, CSR_VOLTAGE_TARGET, 10'd1023, MODE_SAMPLE, 10'd0, 10'd0,
        1'b0, 8'd0, LIMIT_NORMAL, 1'b0},
      '{1'b1, CSR_CURRENT_LIMIT, 10'd1023, MODE_SAMPLE, 10'd0, 10'd0,
        1'b0, 8'd0, LIMIT_NORMAL, 1'b0},
      // base beyond the pwm top, masked to 8 bits and then clamped
      '{1'b1, CSR_DUTY_BASE, 10'd1023, MODE_SAMPLE, 10'd0, 10'd0,
        1'b0, 8'd0, LIMIT_NORMAL, 1'b0},
      '{1'b1, CSR_BOOST_MODE, 10'd1, MODE_SAMPLE, 10'd0, 10'd0,
        1'b0, 8'd0, LIMIT_NORMAL, 1'b0},
      '{1'b0, CSR_VOLTAGE_TARGET, 10'd0, MODE_SAMPLE, 10'd0, 10'd0,
        1'b0, 8'd0, LIMIT_NORMAL, 1'b0},
      '{1'b0, CSR_VOLTAGE_TARGET, 10'd0, MODE_TICK, 10'd0, 10'd0,
        1'b0, 8'd0, LIMIT_NORMAL, 1'b0},
      '{1'b0, CSR_VOLTAGE_TARGET, 10'd0, MODE_TICK, 10'd1023, 10'd1023,
        1'b0, 8'd0, LIMIT_NORMAL, 1'b0},
      '{1'b0, CSR_VOLTAGE_TARGET, 10'd0, MODE_SAMPLE, 10'd1023, 10'd512,
        1'b0, 8'd0, LIMIT_NORMAL, 1'b0},
      // rearm clears limiting but keeps the ceiling
      '{1'b0, CSR_VOLTAGE_TARGET, 10'd0, MODE_REARM, 10'd0, 10'd0,
        1'b0, 8'd0, LIMIT_NORMAL, 1'b0},
      '{1'b0, CSR_VOLTAGE_TARGET, 10'd0, MODE_SAMPLE, 10'd0, 10'd0,
        1'b0, 8'd0, LIMIT_NORMAL, 1'b0},
      '{1'b1, CSR_DUTY_BASE, 10'd0, MODE_SAMPLE, 10'd0, 10'd0,
        1'b0, 8'd0, LIMIT_NORMAL, 1'b0},
      '{1'b1, CSR_BOOST_MODE, 10'd0, MODE_SAMPLE, 10'd0, 10'd0,
        1'b0, 8'd0, LIMIT_NORMAL, 1'b0},
      '{1'b1, CSR_CURRENT_LIMIT, 10'd0, MODE_SAMPLE, 10'd0, 10'd0,
        1'b0, 8'd0, LIMIT_NORMAL, 1'b0},
      '{1'b1, CSR_VOLTAGE_TARGET, 10'd0, MODE_SAMPLE, 10'd0, 10'd0,
        1'b0, 8'd0, LIMIT_NORMAL, 1'b0},
      '{1'b0, CSR_VOLTAGE_TARGET, 10'd0, MODE_TICK, 10'd0, 10'd0,
        1'b0, 8'd0, LIMIT_NORMAL, 1'b0},
      '{1'b0, CSR_VOLTAGE_TARGET, 10'd0, MODE_SAMPLE, 10'd1023, 10'd1023,
        1'b0, 8'd0, LIMIT_NORMAL, 1'b0},
      '{1'b0, CSR_VOLTAGE_TARGET, 10'd0, MODE_TICK, 10'd0, 10'd0,
        1'b0, 8'd0, LIMIT_NORMAL, 1'b0},
      '{1'b0, CSR_VOLTAGE_TARGET, 10'd0, MODE_UNUSED, 10'd0, 10'd0,
        1'b0, 8'd0, LIMIT_NORMAL, 1'b0}
   };

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #1 clock = ~clock;

   // channels and the register port
   bbpcl_req_if req_ch ();
   bbpcl_rsp_if rsp_ch ();
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   buck_boost_pwm_current_limiter dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor copy of the registers
   logic [ADC_W-1:0]  cfg_vtarget = '0;
   logic [ADC_W-1:0]  cfg_ilimit  = CURRENT_LIMIT_RESET;
   logic [DUTY_W-1:0] cfg_base    = '0;
   logic              cfg_boost   = 1'b0;

   // predictor copy of the converter state
   logic [ADC_W-1:0]   vfilt     = '0;
   logic [ADC_W-1:0]   i_prev    = '0;
   logic [CORR_W-1:0]  i_corr    = '0;
   logic [ADC_W-1:0]   i_avg     = '0;
   logic [DUTY_W-1:0]  duty_cap  = '0;
   logic [TMO_W-1:0]   trip_wait = '0;
   logic [STATE_W-1:0] lim_state = LIMIT_NORMAL;

   conv_status_type pending_status [$];
   conv_status_type oldest;

   int snd_idle_pct;
   int rcv_idle_pct;
   int mismatch_count    = 0;
   int responses_checked = 0;
   int cycle_count       = 0;
   int trips_predicted   = 0;
   int clamps_predicted  = 0;
   int mode_seen [4]     = '{0, 0, 0, 0};

   // advance the converter by one request and return the response it must give
   function automatic conv_status_type advance_converter(input logic [MODE_W-1:0] mode,
                                                         input logic [ADC_W-1:0] volt,
                                                         input logic [ADC_W-1:0] curr);
      int sum;
      int half;
      int c;
      int d;
      conv_status_type s;
      d = 0;
      case (mode)
         MODE_SAMPLE: begin
            // voltage filter with the half-current droop, floored at zero
            sum  = vfilt + volt;
            half = i_prev >> 1;
            vfilt = (sum >= half) ? ((sum - half) >> 1) : 0;
            // correction filter on the previous current, saturating
            if (cfg_boost)
               c = ((i_corr * 4) + i_prev) >> 3;
            else
               c = ((i_corr * 2) + i_prev) >> 2;
            i_corr = (c > CORR_MAX) ? CORR_MAX : c;
            if (vfilt > cfg_vtarget || lim_state == LIMIT_TRIPPED) begin
               d = 0;
            end else begin
               d = cfg_base + i_corr;
               if (d > PWM_TOP)
                  d = PWM_TOP;
               if (d > duty_cap) begin
                  d = duty_cap;
                  lim_state = LIMIT_ACTIVE;
                  clamps_predicted++;
               end
            end
            i_prev = curr;
         end
         MODE_TICK: begin
            sum = i_avg + i_prev;
            i_avg = sum >> 1;
            if (i_avg <= cfg_ilimit && lim_state != LIMIT_TRIPPED) begin
               if (duty_cap < PWM_TOP)
                  duty_cap++;
               else
                  lim_state = LIMIT_NORMAL;
            end else if (duty_cap > 0) begin
               duty_cap--;
            end else if (trip_wait > TRIP_DELAY) begin
               trip_wait = '0;
               lim_state = LIMIT_TRIPPED;
               trips_predicted++;
            end else begin
               trip_wait++;
            end
         end
         MODE_REARM: begin
            lim_state = LIMIT_NORMAL;
         end
         default: ;
      endcase
      s.duty  = d[DUTY_W-1:0];
      s.state = lim_state;
      s.cut   = (lim_state == LIMIT_TRIPPED);
      return s;
   endfunction

   // at least half the voltages stay at or below target so that duty is not always forced off
   function automatic logic [ADC_W-1:0] pick_voltage();
      return $urandom_range(1) ? $urandom_range(0, cfg_vtarget) : $urandom_range(0, ADC_MAX);
   endfunction

   // low currents keep the correction small, full range exercises saturation
   function automatic logic [ADC_W-1:0] pick_current();
      return $urandom_range(1) ? $urandom_range(0, 63) : $urandom_range(0, ADC_MAX);
   endfunction

   // response side: random back-pressure
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   // response checker: in-order against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_status.size() == 0) begin
            $error("response with nothing outstanding: duty %0d limit_state %0d power_cut %0d",
                   rsp_ch.duty, rsp_ch.limit_state, rsp_ch.power_cut);
            mismatch_count++;
         end else begin
            oldest = pending_status.pop_front();
            if (rsp_ch.duty !== oldest.duty) begin
               $error("duty: expected %0d, got %0d", oldest.duty, rsp_ch.duty);
               mismatch_count++;
            end
            if (rsp_ch.limit_state !== oldest.state) begin
               $error("limit_state: expected %0d, got %0d", oldest.state, rsp_ch.limit_state);
               mismatch_count++;
            end
            if (rsp_ch.power_cut !== oldest.cut) begin
               $error("power_cut: expected %0d, got %0d", oldest.cut, rsp_ch.power_cut);
               mismatch_count++;
            end
            responses_checked++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // offer one request, wait for the handshake, then record what it must produce
   task automatic send_request(input logic [MODE_W-1:0] mode, input logic [ADC_W-1:0] volt,
                               input logic [ADC_W-1:0] curr, input logic use_table,
                               input conv_status_type table_status);
      conv_status_type predicted;
      while ($urandom_range(99) < snd_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.mode           <= mode;
      req_ch.voltage_sample <= volt;
      req_ch.current_sample <= curr;
      do @(posedge clock); while (!req_ch.ready);
      predicted = advance_converter(mode, volt, curr);
      pending_status.push_back(use_table ? table_status : predicted);
      mode_seen[mode]++;
   endtask

   // stop offering requests until every response is back
   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_status.size() != 0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_VOLTAGE_TARGET: cfg_vtarget = data[ADC_W-1:0];
         CSR_CURRENT_LIMIT:  cfg_ilimit  = data[ADC_W-1:0];
         CSR_DUTY_BASE:      cfg_base    = data[DUTY_W-1:0];
         CSR_BOOST_MODE:     cfg_boost   = data[0];
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] vt, input logic [CSR_DATA_W-1:0] lim,
                             input logic [CSR_DATA_W-1:0] base, input logic [CSR_DATA_W-1:0] boost);
      wait_for_drain();
      write_reg(CSR_VOLTAGE_TARGET, vt);
      write_reg(CSR_CURRENT_LIMIT, lim);
      write_reg(CSR_DUTY_BASE, base);
      write_reg(CSR_BOOST_MODE, boost);
   endtask

   // random bursts shaped like real converter traffic
   task automatic random_phase(input int quota);
      int sent;
      int n;
      int roll;
      logic [MODE_W-1:0] pick;
      logic [ADC_W-1:0]  heavy;
      sent = 0;
      while (sent < quota) begin
         roll = $urandom_range(99);
         if (roll < 45) begin
            // mixed samples and ticks, with occasional rearms and unused codes, around the operating point
            n = $urandom_range(8, 30);
            repeat (n) begin
               roll = $urandom_range(99);
               pick = (roll < 60) ? MODE_SAMPLE : (roll < 88) ? MODE_TICK :
                      (roll < 95) ? MODE_REARM : MODE_UNUSED;
               send_request(pick, pick_voltage(), pick_current(), 1'b0, '0);
               if (pick != MODE_UNUSED)
                  sent++;
            end
         end else if (roll < 65) begin
            // low current then a run of ticks: ceiling climbs, limiting clears at the top
            send_request(MODE_SAMPLE, pick_voltage(), $urandom_range(0, cfg_ilimit), 1'b0, '0);
            n = $urandom_range(20, 200);
            repeat (n)
               send_request(MODE_TICK, $urandom_range(0, ADC_MAX), $urandom_range(0, ADC_MAX),
                            1'b0, '0);
            sent += n + 1;
         end else if (roll < 95) begin
            // overload: ceiling falls to zero, timeout expires, block trips and cuts power;
            // the short variant rearms somewhere during the countdown
            heavy = (cfg_ilimit >= 10'd1000) ? $urandom_range(0, ADC_MAX) :
                    $urandom_range(cfg_ilimit + 2, ADC_MAX);
            send_request(MODE_SAMPLE, pick_voltage(), heavy, 1'b0, '0);
            if (roll < 88)
               n = duty_cap + TRIP_DELAY + 40 + $urandom_range(0, 4);
            else
               n = $urandom_range(1, duty_cap + TRIP_DELAY);
            repeat (n)
               send_request(MODE_TICK, $urandom_range(0, ADC_MAX), $urandom_range(0, ADC_MAX),
                            1'b0, '0);
            // samples while tripped must come back with zero duty
            repeat ($urandom_range(1, 4))
               send_request(MODE_SAMPLE, pick_voltage(), heavy, 1'b0, '0);
            send_request(MODE_UNUSED, pick_voltage(), pick_current(), 1'b0, '0);
            send_request(MODE_REARM, pick_voltage(), pick_current(), 1'b0, '0);
            sent += n + 3;
         end else begin
            // hold off until the pipeline is empty
            wait_for_drain();
         end
      end
   endtask

   initial begin
      conv_status_type table_status;
      // everything known before the first edge
      req_ch.valid          = 1'b0;
      req_ch.mode           = MODE_SAMPLE;
      req_ch.voltage_sample = '0;
      req_ch.current_sample = '0;
      rsp_ch.ready          = 1'b0;
      csr_we                = 1'b0;
      csr_index             = CSR_VOLTAGE_TARGET;
      csr_wdata             = '0;
      snd_idle_pct          = 38;
      rcv_idle_pct          = 49;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed script, starting from reset settings
      for (int r = 0; r < SCRIPT_LEN; r++) begin
         if (SCRIPT[r].is_csr) begin
            wait_for_drain();
            write_reg(SCRIPT[r].reg_idx, SCRIPT[r].reg_val);
         end else begin
            table_status.duty  = SCRIPT[r].duty;
            table_status.state = SCRIPT[r].state;
            table_status.cut   = SCRIPT[r].cut;
            send_request(SCRIPT[r].mode, SCRIPT[r].volt, SCRIPT[r].curr,
                         SCRIPT[r].typed_in, table_status);
         end
      end

      // sender idles more lightly than the receiver, wide-open target, top base
      set_config(10'd1023, 10'd600, 10'd188, 10'd0);
      random_phase(PHASE_QUOTA);

      // roles swapped, boost filter, tight current limit
      snd_idle_pct = 49;
      rcv_idle_pct = 38;
      set_config($urandom_range(300, 700), $urandom_range(0, 200), $urandom_range(0, 188), 10'd1);
      random_phase(PHASE_QUOTA);

      // full rate both ways, base may exceed the pwm top, boost bit from wider data
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      set_config($urandom_range(400, 1023), $urandom_range(100, 900), $urandom_range(0, 255),
                 $urandom_range(0, 3));
      random_phase(PHASE_QUOTA);

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d samples, %0d ticks, %0d rearms, %0d unused-code requests",
               mode_seen[MODE_SAMPLE], mode_seen[MODE_TICK], mode_seen[MODE_REARM],
               mode_seen[MODE_UNUSED]);
      $display("%0d trips, %0d ceiling clamps, %0d responses checked, %0d mismatches",
               trips_predicted, clamps_predicted, responses_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
